>>> rtl/lsr_pkg.sv
package lsr_pkg;

    localparam int COORD_W   = 6;
    localparam int TILE_SIZE = 64;
    localparam int ERR_W     = COORD_W + 1;
    localparam int COLOR_W   = 32;

    localparam int S_FIELDS_W = 4 * COORD_W + COLOR_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 * COORD_W + COLOR_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ERR_W-1:0]   err_t;
    typedef logic [COLOR_W-1:0] color_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } lsr_state_t;

    typedef struct packed {
        logic load;
        logic emit;
        logic busy;
    } lsr_ctrl_t;

    function automatic coord_t sat_coord(input coord_t c);
        coord_t r;
        r = c;
        if (ERR_W'(c) >= ERR_W'(TILE_SIZE)) begin
            r = COORD_W'(TILE_SIZE - 1);
        end
        return r;
    endfunction

endpackage

>>> rtl/lsr_walker.sv
module lsr_walker (
    input  logic                aclk,
    input  lsr_pkg::lsr_ctrl_t  ctrl,
    input  lsr_pkg::coord_t     start_x,
    input  lsr_pkg::coord_t     start_y,
    input  lsr_pkg::coord_t     end_x,
    input  lsr_pkg::coord_t     end_y,
    input  lsr_pkg::color_t     pixel_color,
    output lsr_pkg::coord_t     pix_x,
    output lsr_pkg::coord_t     pix_y,
    output lsr_pkg::color_t     pix_color,
    output logic                last_pixel,
    output lsr_pkg::err_t       err_level,
    output lsr_pkg::coord_t     major_len,
    output lsr_pkg::coord_t     step_count
);
    import lsr_pkg::*;

    coord_t x_reg, x_next;
    coord_t y_reg, y_next;
    err_t   err_reg, err_next;
    coord_t cnt_reg, cnt_next;
    coord_t major_reg, major_next;
    coord_t minor_reg, minor_next;
    logic   x_up_reg, x_up_next;
    logic   y_up_reg, y_up_next;
    logic   y_major_reg, y_major_next;
    color_t color_reg, color_next;

    coord_t sx, sy, ex, ey, dx, dy;
    err_t   err_sum;
    logic   minor_step;

    always_comb begin
        sx = sat_coord(start_x);
        sy = sat_coord(start_y);
        ex = sat_coord(end_x);
        ey = sat_coord(end_y);
        dx = (ex >= sx) ? ex - sx : sx - ex;
        dy = (ey >= sy) ? ey - sy : sy - ey;

        err_sum    = err_reg + ERR_W'(minor_reg);
        minor_step = (major_reg != '0) && (err_sum >= ERR_W'(major_reg));

        x_next       = x_reg;
        y_next       = y_reg;
        err_next     = err_reg;
        cnt_next     = cnt_reg;
        major_next   = major_reg;
        minor_next   = minor_reg;
        x_up_next    = x_up_reg;
        y_up_next    = y_up_reg;
        y_major_next = y_major_reg;
        color_next   = color_reg;

        if (ctrl.load) begin
            x_next       = sx;
            y_next       = sy;
            x_up_next    = ex >= sx;
            y_up_next    = ey >= sy;
            y_major_next = dx <= dy;
            major_next   = (dx <= dy) ? dy : dx;
            minor_next   = (dx <= dy) ? dx : dy;
            err_next     = ERR_W'((dx <= dy) ? dx : dy);
            cnt_next     = '0;
            color_next   = pixel_color;
        end else if (ctrl.emit) begin
            cnt_next = cnt_reg + 1'b1;
            err_next = minor_step ? err_sum - ERR_W'(major_reg) : err_sum;
            if (y_major_reg) begin
                y_next = y_up_reg ? y_reg + 1'b1 : y_reg - 1'b1;
                if (minor_step) begin
                    x_next = x_up_reg ? x_reg + 1'b1 : x_reg - 1'b1;
                end
            end else begin
                x_next = x_up_reg ? x_reg + 1'b1 : x_reg - 1'b1;
                if (minor_step) begin
                    y_next = y_up_reg ? y_reg + 1'b1 : y_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        err_reg     <= err_next;
        cnt_reg     <= cnt_next;
        major_reg   <= major_next;
        minor_reg   <= minor_next;
        x_up_reg    <= x_up_next;
        y_up_reg    <= y_up_next;
        y_major_reg <= y_major_next;
        color_reg   <= color_next;
    end

    assign pix_x      = x_reg;
    assign pix_y      = y_reg;
    assign pix_color  = color_reg;
    assign last_pixel = cnt_reg == major_reg;
    assign err_level  = err_reg;
    assign major_len  = major_reg;
    assign step_count = cnt_reg;

endmodule

>>> rtl/lsr_ctrl.sv
module lsr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               req_valid,
    input  logic               out_free,
    input  logic               last_pixel,
    output logic               req_ready,
    output lsr_pkg::lsr_ctrl_t ctrl
);
    import lsr_pkg::*;

    lsr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        req_ready  = 1'b0;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    ctrl.load  = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                ctrl.busy = 1'b1;
                if (out_free) begin
                    ctrl.emit = 1'b1;
                    if (last_pixel) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/line_segment_rasterizer_top.sv
// Line segment rasteriser for a 64 by 64 pixel tile.
// The slave channel takes one segment per request: start and end pixel
// coordinates and a colour. The master channel returns the pixels of that
// segment in order from start to end, one per request, each with the colour;
// tlast marks the final pixel. A segment whose major delta is N gives N + 1
// pixels, and a zero-length segment gives one pixel.
// After a segment is accepted, the walker registers load its start point,
// then its first pixel is registered onto the master channel, and further
// pixels follow one per cycle while the receiver takes them. The single
// error and coordinate stepping unit produces one pixel per cycle while
// the output register is free. s_tready is high only while no segment is
// being walked.
// Reset clears the sequencer and the output valid flag; any segment in
// progress is dropped. When the receiver holds m_tready low, the walk pauses
// and the current pixel stays on the master channel until it is taken.
module line_segment_rasterizer_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x, start_y, end_x, end_y, pixel_color
    input  logic [lsr_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pix_x, pix_y, pix_color, zero padding
    output logic [lsr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import lsr_pkg::*;

    lsr_ctrl_t ctrl;
    coord_t    pix_x, pix_y, major_len, step_count;
    color_t    pix_color;
    err_t      err_level;
    logic      last_pixel;
    logic      out_free;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;

    assign out_free = !m_valid_reg || m_tready;

    lsr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .out_free   (out_free),
        .last_pixel (last_pixel),
        .req_ready  (s_tready),
        .ctrl       (ctrl)
    );

    lsr_walker u_walker (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .start_x     (s_tdata[COORD_W-1:0]),
        .start_y     (s_tdata[2*COORD_W-1:COORD_W]),
        .end_x       (s_tdata[3*COORD_W-1:2*COORD_W]),
        .end_y       (s_tdata[4*COORD_W-1:3*COORD_W]),
        .pixel_color (s_tdata[4*COORD_W+COLOR_W-1:4*COORD_W]),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .pix_color   (pix_color),
        .last_pixel  (last_pixel),
        .err_level   (err_level),
        .major_len   (major_len),
        .step_count  (step_count)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (ctrl.emit) begin
            m_valid_next = 1'b1;
            m_data_next  = M_TDATA_W'({pix_color, pix_y, pix_x});
            m_last_next  = last_pixel;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.busy |-> step_count <= major_len)
        else $error("pixel count passed the major delta");

    a_err_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.busy |-> err_level <= ERR_W'(major_len))
        else $error("error term exceeded the major delta");

    a_load_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (ctrl.busy && step_count == '0))
        else $error("accepted segment did not start a walk at its first pixel");

    a_last_ends_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.emit && last_pixel) |=> (!ctrl.busy && m_tvalid && m_tlast))
        else $error("final pixel did not end the walk");
`endif

endmodule

>>> tb/sv/tb_line_segment_rasterizer_top.sv
module tb_line_segment_rasterizer_top;

    import lsr_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        coord_t x;
        coord_t y;
        color_t color;
        bit     last;
    } pixel_t;

    class pixel_scoreboard;
        pixel_t expected_px[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Walks the segment with an integer error scaled by the major delta.
        function void note_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                   color_t color);
            int     dx, dy, major, minor, err;
            bit     x_up, y_up, y_major;
            coord_t x, y;
            pixel_t p;
            x_up    = ex >= sx;
            y_up    = ey >= sy;
            dx      = x_up ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
            dy      = y_up ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
            y_major = dx <= dy;
            major   = y_major ? dy : dx;
            minor   = y_major ? dx : dy;
            x       = sx;
            y       = sy;
            err     = minor;
            for (int i = 0; i <= major; i++) begin
                p.x     = x;
                p.y     = y;
                p.color = color;
                p.last  = (i == major);
                expected_px.push_back(p);
                err += minor;
                if (major != 0 && err >= major) begin
                    err -= major;
                    if (y_major) begin
                        x = x_up ? x + 1'b1 : x - 1'b1;
                    end else begin
                        y = y_up ? y + 1'b1 : y - 1'b1;
                    end
                end
                if (y_major) begin
                    y = y_up ? y + 1'b1 : y - 1'b1;
                end else begin
                    x = x_up ? x + 1'b1 : x - 1'b1;
                end
            end
        endfunction

        function void check_pixel(coord_t x, coord_t y, color_t color, bit last);
            pixel_t p;
            if (expected_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected pixel: x=%0d y=%0d color=%08h last=%0b",
                             x, y, color, last);
                end
                return;
            end
            p = expected_px.pop_front();
            if (p.x !== x || p.y !== y || p.color !== color || p.last !== last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("pixel mismatch: expected x=%0d y=%0d color=%08h last=%0b, got x=%0d y=%0d color=%08h last=%0b",
                             p.x, p.y, p.color, p.last, x, y, color, last);
                end
            end
        endfunction

        function int pending();
            return expected_px.size();
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    pixel_scoreboard pixels = new();
    int              cycle_count = 0;
    int              burst_left  = 4;
    bit              hold_req    = 1'b0;

    line_segment_rasterizer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_line_segment_rasterizer_top: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            pixels.check_pixel(m_tdata[COORD_W-1:0], m_tdata[2*COORD_W-1:COORD_W],
                               m_tdata[2*COORD_W+COLOR_W-1:2*COORD_W], m_tlast);
        end
    end

    // The receiver switches its stall pattern at random and, when asked,
    // holds off for a long stretch so that the block backs up onto its input.
    initial begin
        int mode, left, n;
        mode = 0;
        left = 0;
        n    = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 4);
                left = $urandom_range(20, 120);
            end
            left--;
            n++;
            case (mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_tready <= ($urandom_range(0, 7) != 0);
                end
                3: begin
                    m_tready <= ((n % 5) < 3);
                end
                default: begin
                    m_tready <= ((n % 7) == 0);
                end
            endcase
        end
    end

    function automatic coord_t clamp_coord(int v);
        if (v < 0) begin
            return '0;
        end
        if (v > TILE_SIZE - 1) begin
            return coord_t'(TILE_SIZE - 1);
        end
        return coord_t'(v);
    endfunction

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic offer_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                 color_t color);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[COORD_W-1:0]           = sx;
        word[2*COORD_W-1:COORD_W]   = sy;
        word[3*COORD_W-1:2*COORD_W] = ex;
        word[4*COORD_W-1:3*COORD_W] = ey;
        word[4*COORD_W+COLOR_W-1:4*COORD_W] = color;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pixels.note_segment(sx, sy, ex, ey, color);
        pace();
    endtask

    // Mostly short segments, with some spanning the tile, some between corners
    // and some of zero length.
    task automatic random_segment();
        int kind, sx, sy, ex, ey;
        kind = $urandom_range(0, 19);
        sx   = $urandom_range(0, TILE_SIZE - 1);
        sy   = $urandom_range(0, TILE_SIZE - 1);
        if (kind < 12) begin
            ex = sx + $urandom_range(0, 30) - 15;
            ey = sy + $urandom_range(0, 30) - 15;
        end else if (kind < 16) begin
            ex = $urandom_range(0, TILE_SIZE - 1);
            ey = $urandom_range(0, TILE_SIZE - 1);
        end else if (kind < 19) begin
            sx = $urandom_range(0, 1) ? TILE_SIZE - 1 : 0;
            sy = $urandom_range(0, 1) ? TILE_SIZE - 1 : 0;
            ex = $urandom_range(0, 1) ? TILE_SIZE - 1 : 0;
            ey = $urandom_range(0, 1) ? TILE_SIZE - 1 : 0;
        end else begin
            ex = sx;
            ey = sy;
        end
        offer_segment(clamp_coord(sx), clamp_coord(sy), clamp_coord(ex),
                      clamp_coord(ey), $urandom());
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer_segment(6'd0,  6'd0,  6'd0,  6'd0,  32'h0000_0000);
        offer_segment(6'd63, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF);
        offer_segment(6'd0,  6'd0,  6'd63, 6'd0,  32'hAAAA_AAAA);
        offer_segment(6'd63, 6'd0,  6'd0,  6'd0,  32'h5555_5555);
        offer_segment(6'd0,  6'd0,  6'd0,  6'd63, 32'hFFFF_0000);
        offer_segment(6'd0,  6'd63, 6'd0,  6'd0,  32'h0000_FFFF);
        offer_segment(6'd0,  6'd0,  6'd63, 6'd63, 32'h8000_0001);
        offer_segment(6'd63, 6'd63, 6'd0,  6'd0,  32'h7FFF_FFFE);
        offer_segment(6'd0,  6'd63, 6'd63, 6'd0,  32'h0F0F_0F0F);
        offer_segment(6'd63, 6'd0,  6'd0,  6'd63, 32'hF0F0_F0F0);
        offer_segment(6'd5,  6'd10, 6'd45, 6'd20, 32'h1234_5678);
        offer_segment(6'd45, 6'd20, 6'd5,  6'd10, 32'h9ABC_DEF0);
        offer_segment(6'd10, 6'd5,  6'd20, 6'd45, 32'hDEAD_BEEF);
        offer_segment(6'd20, 6'd45, 6'd10, 6'd5,  32'hCAFE_F00D);
        offer_segment(6'd0,  6'd0,  6'd1,  6'd0,  32'h0000_0001);
        offer_segment(6'd7,  6'd7,  6'd8,  6'd9,  32'h8000_0000);
        offer_segment(6'd32, 6'd32, 6'd0,  6'd63, 32'h3333_3333);
        offer_segment(6'd3,  6'd60, 6'd60, 6'd3,  32'hCCCC_CCCC);
        offer_segment(6'd30, 6'd30, 6'd31, 6'd31, 32'h0101_0101);
        offer_segment(6'd21, 6'd42, 6'd42, 6'd21, 32'hFEFE_FEFE);
        offer_segment(6'd62, 6'd1,  6'd1,  6'd2,  32'h6996_6996);

        for (int i = 0; i < 350; i++) begin
            if (i == 40 || i == 220) begin
                hold_req = 1'b1;
            end
            random_segment();
        end
        s_tvalid <= 1'b0;

        while (pixels.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (70) @(posedge aclk);

        if (pixels.mismatches == 0) begin
            $display("tb_line_segment_rasterizer_top: done, clean");
        end else begin
            $display("tb_line_segment_rasterizer_top: done, errors");
        end
        $finish;
    end

endmodule

>>> line_segment_rasterizer_top.f
rtl/lsr_pkg.sv
rtl/lsr_walker.sv
rtl/lsr_ctrl.sv
rtl/line_segment_rasterizer_top.sv
tb/sv/tb_line_segment_rasterizer_top.sv
